[design/assert_macros.svh]
// assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent property on clk, off while rst_n is low
`define ASSERT_PROP(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// next-cycle implication on clk, off while rst_n is low
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/mt_pkg.sv]
// constants, types and word functions of the mersenne twister generator
package mt_pkg;

    localparam int STATE_WORDS = 624;
    localparam int IDX_W = $clog2(STATE_WORDS);
    localparam int MT_SHIFT = 397;

    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(STATE_WORDS - 1);
    localparam logic [IDX_W-1:0] IDX_SHIFT = IDX_W'(MT_SHIFT);
    localparam logic [IDX_W-1:0] IDX_WRAP = IDX_W'(STATE_WORDS - MT_SHIFT);

    localparam logic [31:0] MT_MULT = 32'd1812433253;
    localparam logic [31:0] MT_UPPER = 32'h8000_0000;
    localparam logic [31:0] MT_LOWER = 32'h7fff_ffff;
    localparam logic [31:0] MT_MATRIX = 32'd2567483615;
    localparam logic [31:0] MT_TEMPER_B = 32'd2636928640;
    localparam logic [31:0] MT_TEMPER_C = 32'd4022730752;
    localparam logic [31:0] MT_DEFAULT_SEED = 32'd5489;

    localparam logic [1:0] OP_RESEED = 2'd0;
    localparam logic [1:0] OP_DRAW32 = 2'd1;
    localparam logic [1:0] OP_DRAW64 = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef logic [IDX_W-1:0] idx_t;

    typedef struct packed {
        logic        en;
        idx_t        addr;
        logic [31:0] data;
    } ram_wr_t;

    typedef struct packed {
        logic en;
        idx_t addr_a;
        idx_t addr_b;
    } ram_rd_t;

    function automatic idx_t idx_inc(input idx_t i);
        idx_t r;
        if (i == IDX_LAST)
        begin
            r = '0;
        end
        else
        begin
            r = i + idx_t'(1);
        end
        return r;
    endfunction

    function automatic idx_t idx_far(input idx_t i);
        idx_t r;
        if (i >= IDX_WRAP)
        begin
            r = i - IDX_WRAP;
        end
        else
        begin
            r = i + IDX_SHIFT;
        end
        return r;
    endfunction

    function automatic logic [31:0] twist(input logic [31:0] cur, input logic [31:0] nxt,
                                          input logic [31:0] far);
        logic [31:0] y;
        logic [31:0] v;
        y = (cur & MT_UPPER) | (nxt & MT_LOWER);
        v = far ^ (y >> 1);
        if (y[0])
        begin
            v = v ^ MT_MATRIX;
        end
        return v;
    endfunction

    function automatic logic [31:0] temper(input logic [31:0] w);
        logic [31:0] y;
        y = w;
        y = y ^ (y >> 11);
        y = y ^ ((y << 7) & MT_TEMPER_B);
        y = y ^ ((y << 15) & MT_TEMPER_C);
        y = y ^ (y >> 18);
        return y;
    endfunction

endpackage

[design/mt_state_ram.sv]
// state word memory: one write port, two registered read ports
module mt_state_ram
    import mt_pkg::*;
(
    input  logic        clk,
    input  ram_wr_t     wr,
    input  ram_rd_t     rd,
    output logic [31:0] rd_a,
    output logic [31:0] rd_b
);

    logic [31:0] mem [STATE_WORDS];
    logic [31:0] rd_a_reg;
    logic [31:0] rd_b_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd.en)
        begin
            rd_a_reg <= mem[rd.addr_a];
            rd_b_reg <= mem[rd.addr_b];
        end
    end

    assign rd_a = rd_a_reg;
    assign rd_b = rd_b_reg;

endmodule

[design/mt_seeder.sv]
// seed expansion: one state word per cycle into the memory
module mt_seeder
    import mt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] seed,
    output logic        busy,
    output ram_wr_t     wr
);

    logic        busy_reg;
    logic        busy_next;
    idx_t        cnt_reg;
    idx_t        cnt_next;
    logic [31:0] word_reg;
    logic [31:0] word_next;
    logic [31:0] mix;
    logic [31:0] prod;

    assign mix  = word_reg ^ (word_reg >> 30);
    assign prod = mix * MT_MULT;

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        word_next = word_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            word_next = seed;
        end
        else if (busy_reg)
        begin
            cnt_next  = idx_inc(cnt_reg);
            word_next = prod + {{(32-IDX_W){1'b0}}, cnt_reg} + 32'd1;
            if (cnt_reg == IDX_LAST)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
            word_reg <= MT_DEFAULT_SEED;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
            word_reg <= word_next;
        end
    end

    assign busy    = busy_reg;
    assign wr.en   = busy_reg;
    assign wr.addr = cnt_reg;
    assign wr.data = word_reg;

endmodule

[design/mt19937_random_generator.sv]
// top level of the mt19937 generator: control, lazy twist and tempering
//
//  channel  direction  handshake                   payload
//  item     in         item_valid / item_stall     opcode, seed_value
//  result   out        result_valid / result_stall random_value
//
// reset fills the state from seed 5489 with item_stall high
// a reseed transaction starts the seeder, which then refills the memory
// a 32-bit draw handles one state word, a 64-bit draw two: each word is a
// memory read followed by a twist, write-back and temper step
// the last word of a draw waits while the result register is full and stalled
module mt19937_random_generator
    import mt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_stall,
    input  logic [1:0]  opcode,
    input  logic [31:0] seed_value,
    output logic        result_valid,
    input  logic        result_stall,
    output logic [63:0] random_value
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_WORD = 1'b1;

    logic        state_reg;
    logic        state_next;
    idx_t        idx_reg;
    idx_t        idx_next;
    logic [31:0] cur_reg;
    logic [31:0] cur_next;
    logic        wide_reg;
    logic        wide_next;
    logic        first_reg;
    logic        first_next;
    logic [31:0] lo_reg;
    logic [31:0] lo_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [63:0] out_data_reg;
    logic [63:0] out_data_next;

    logic        seed_busy;
    logic        seed_start;
    ram_wr_t     seed_wr;
    ram_wr_t     tw_wr;
    ram_wr_t     ram_wr;
    ram_rd_t     ram_rd;
    logic [31:0] rd_a;
    logic [31:0] rd_b;

    logic        accept;
    logic        out_free;
    logic        final_word;
    logic [31:0] tw_word;
    logic [31:0] tp_word;
    idx_t        idx_n;

    assign item_stall = (state_reg != ST_IDLE) || seed_busy;
    assign accept     = item_valid && !item_stall;
    assign out_free   = !out_valid_reg || !result_stall;
    assign final_word = !wide_reg || !first_reg;
    assign tw_word    = twist(cur_reg, rd_a, rd_b);
    assign tp_word    = temper(tw_word);
    assign idx_n      = idx_inc(idx_reg);

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        cur_next       = cur_reg;
        wide_next      = wide_reg;
        first_next     = first_reg;
        lo_next        = lo_reg;
        out_valid_next = out_valid_reg && result_stall;
        out_data_next  = out_data_reg;
        seed_start     = 1'b0;
        tw_wr          = '0;
        ram_rd         = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (opcode == OP_RESEED)
                    begin
                        seed_start = 1'b1;
                        cur_next   = seed_value;
                        idx_next   = '0;
                    end
                    else if (opcode == OP_DRAW32 || opcode == OP_DRAW64)
                    begin
                        ram_rd.en     = 1'b1;
                        ram_rd.addr_a = idx_n;
                        ram_rd.addr_b = idx_far(idx_reg);
                        wide_next     = (opcode == OP_DRAW64);
                        first_next    = 1'b1;
                        state_next    = ST_WORD;
                    end
                end
            end
            ST_WORD:
            begin
                if (!final_word)
                begin
                    tw_wr.en      = 1'b1;
                    tw_wr.addr    = idx_reg;
                    tw_wr.data    = tw_word;
                    idx_next      = idx_n;
                    cur_next      = rd_a;
                    lo_next       = tp_word;
                    first_next    = 1'b0;
                    ram_rd.en     = 1'b1;
                    ram_rd.addr_a = idx_inc(idx_n);
                    ram_rd.addr_b = idx_far(idx_n);
                end
                else if (out_free)
                begin
                    tw_wr.en       = 1'b1;
                    tw_wr.addr     = idx_reg;
                    tw_wr.data     = tw_word;
                    idx_next       = idx_n;
                    cur_next       = rd_a;
                    out_valid_next = 1'b1;
                    out_data_next  = wide_reg ? {tp_word, lo_reg} : {32'd0, tp_word};
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign ram_wr = seed_wr.en ? seed_wr : tw_wr;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            cur_reg       <= MT_DEFAULT_SEED;
            wide_reg      <= 1'b0;
            first_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            cur_reg       <= cur_next;
            wide_reg      <= wide_next;
            first_reg     <= first_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg       <= lo_next;
        out_data_reg <= out_data_next;
    end

    mt_seeder u_seeder
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (seed_start),
        .seed  (seed_value),
        .busy  (seed_busy),
        .wr    (seed_wr)
    );

    mt_state_ram u_ram
    (
        .clk  (clk),
        .wr   (ram_wr),
        .rd   (ram_rd),
        .rd_a (rd_a),
        .rd_b (rd_b)
    );

    assign result_valid = out_valid_reg;
    assign random_value = out_data_reg;

endmodule

[design/mt_checker.sv]
// port-level checker for the mt19937 generator, bound to the top level
`include "assert_macros.svh"

module mt_checker
    import mt_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        item_valid,
    input logic        item_stall,
    input logic [1:0]  opcode,
    input logic        result_valid,
    input logic        result_stall,
    input logic [63:0] random_value
);

    logic item_take;
    logic seed_take;
    logic draw_take;
    logic nop_take;

    assign item_take = item_valid && !item_stall;
    assign seed_take = item_take && (opcode == OP_RESEED);
    assign draw_take = item_take && (opcode == OP_DRAW32 || opcode == OP_DRAW64);
    assign nop_take  = item_take && (opcode == OP_UNUSED);

    `ASSERT_NEXT(a_result_hold, result_valid && result_stall,
        result_valid && $stable(random_value), "stalled result transaction changed")
    `ASSERT_NEXT(a_draw_busy, draw_take, item_stall, "draw did not hold off the next transaction")
    `ASSERT_NEXT(a_seed_busy, seed_take, item_stall, "reseed did not hold off the next transaction")
    `ASSERT_NEXT(a_nop_free, nop_take, !item_stall, "unused opcode left the block busy")

endmodule

bind mt19937_random_generator mt_checker u_mt_checker (.*);
